// File: rtl/ils_pkg.sv
// Shared constants, codes and types for the integer literal scanner.
`timescale 1ns / 1ps

package ils_pkg;

  localparam int unsigned VALUE_BITS_DEFAULT = 64;

  // Payload widths of the stream ports.
  localparam int unsigned CH_W     = 8;
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72;

  // Scanner phase codes.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  // Radix selector codes.
  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_BIN = 2'd1;
  localparam logic [1:0] RX_OCT = 2'd2;
  localparam logic [1:0] RX_HEX = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_UNKNOWN_BASE = 3'd1;
  localparam logic [2:0] ST_LETTER       = 3'd2;
  localparam logic [2:0] ST_FRACTION     = 3'd3;
  localparam logic [2:0] ST_NOT_DIGIT    = 3'd4;

  // Character codes.
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  // Control outcome of one character step.
  typedef struct packed {
    logic [1:0] phase;
    logic [1:0] radix;
    logic       emit;
    logic [2:0] status;
    logic       use_accum;
  } ils_step_t;

endpackage

// File: rtl/ils_step.sv
// Next-state and result logic for one character of a literal.
`timescale 1ns / 1ps

module ils_step import ils_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic [CH_W-1:0]       ch,
  input  logic                  first,
  input  logic [1:0]            phase,
  input  logic [1:0]            radix,
  input  logic [VALUE_BITS-1:0] accum,
  output ils_step_t             step,
  output logic [VALUE_BITS-1:0] accum_next
);

  logic [7:0]            lower;
  logic                  is_dec;
  logic                  is_letter;
  logic                  dig_ok;
  logic [3:0]            dig_val;
  logic [VALUE_BITS-1:0] scaled;

  assign lower     = ch | CASE_BIT;
  assign is_dec    = ch inside {[CH_0:CH_9]};
  assign is_letter = lower inside {[CH_A:CH_Z]};

  // Digit decode for the selected radix.
  always_comb begin
    dig_ok  = 1'b0;
    dig_val = ch[3:0];
    case (radix)
      RX_BIN: dig_ok = ch inside {[CH_0:CH_1]};
      RX_OCT: dig_ok = ch inside {[CH_0:CH_7]};
      RX_HEX: begin
        if (is_dec) begin
          dig_ok = 1'b1;
        end else if (lower inside {[CH_A:CH_F]}) begin
          dig_ok  = 1'b1;
          dig_val = 4'(lower[3:0] + 4'd9);
        end
      end
      default: dig_ok = is_dec;
    endcase
  end

  // Multiply by the base with shifts and one add.
  always_comb begin
    case (radix)
      RX_BIN:  scaled = accum << 1;
      RX_OCT:  scaled = accum << 3;
      RX_HEX:  scaled = accum << 4;
      default: scaled = (accum << 3) + (accum << 1);
    endcase
  end

  always_comb begin
    step.phase     = phase;
    step.radix     = radix;
    step.emit      = 1'b0;
    step.status    = ST_OK;
    step.use_accum = 1'b0;
    accum_next     = accum;
    if (first) begin
      step.radix = RX_DEC;
      accum_next = '0;
      if (ch == CH_0) begin
        step.phase = PH_ZERO;
      end else if (is_dec) begin
        step.phase = PH_DIGITS;
        accum_next = VALUE_BITS'(ch[3:0]);
      end else begin
        step.emit   = 1'b1;
        step.status = ST_NOT_DIGIT;
        step.phase  = PH_IDLE;
      end
    end else begin
      case (phase)
        PH_ZERO: begin
          accum_next = '0;
          if (lower == CH_B) begin
            step.radix = RX_BIN;
            step.phase = PH_DIGITS;
          end else if (lower == CH_X || lower == CH_H) begin
            step.radix = RX_HEX;
            step.phase = PH_DIGITS;
          end else if (lower == CH_O) begin
            step.radix = RX_OCT;
            step.phase = PH_DIGITS;
          end else if (lower == CH_D) begin
            step.radix = RX_DEC;
            step.phase = PH_DIGITS;
          end else begin
            // A bare zero ends cleanly; a zero followed by a digit is an error.
            step.emit   = 1'b1;
            step.status = is_dec ? ST_UNKNOWN_BASE : ST_OK;
            step.phase  = PH_IDLE;
          end
        end
        PH_DIGITS: begin
          if (dig_ok) begin
            accum_next = scaled + VALUE_BITS'(dig_val);
          end else begin
            step.emit  = 1'b1;
            step.phase = PH_IDLE;
            accum_next = '0;
            if (is_letter && lower != CH_E) begin
              step.status = ST_LETTER;
            end else if (ch == CH_DOT || lower == CH_E) begin
              step.status = ST_FRACTION;
            end else begin
              step.use_accum = 1'b1;
            end
          end
        end
        default: step.phase = PH_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/integer_literal_scanner.sv
// Top level of the prefixed integer literal scanner.
`timescale 1ns / 1ps

// Channel  Direction  Data                                   User
// s_axis   in         tdata[7:0] ch                          tuser first
// m_axis   out        tdata[63:0] value, [66:64] status      -
//
// Each accepted character goes into an input register and is processed from
// there once the output register is free. A result, if any, is then registered
// in the output register, which raises m_tvalid. One character per cycle is
// accepted as long as results are taken.
// The input register only stalls when the output register holds an untaken
// result. Reset clears the scanner to idle, decimal, zero value.

module integer_literal_scanner import ils_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] ch
  input  logic                   s_tuser,   // [0] first
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [63:0] value, [66:64] status, rest zero
);

  logic                  in_valid;
  logic [CH_W-1:0]       in_ch;
  logic                  in_first;
  logic [1:0]            phase;
  logic [1:0]            radix;
  logic [VALUE_BITS-1:0] accum;
  logic [VALUE_BITS-1:0] accum_next;
  ils_step_t             step;
  logic                  advance;
  logic [VAL_W-1:0]      value_out;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch    <= s_tdata[CH_W-1:0];
      in_first <= s_tuser;
    end
  end

  ils_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .ch        (in_ch),
    .first     (in_first),
    .phase     (phase),
    .radix     (radix),
    .accum     (accum),
    .step      (step),
    .accum_next(accum_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      radix <= RX_DEC;
      accum <= '0;
    end else if (advance) begin
      phase <= step.phase;
      radix <= step.radix;
      accum <= accum_next;
    end
  end

  assign value_out = step.use_accum ? VAL_W'(accum) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && step.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.emit) begin
      m_tdata <= {(OUT_TDATA_W - VAL_W - STATUS_W)'(0), step.status, value_out};
    end
  end

  a_err_zero_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[66:64] != ST_OK |-> m_tdata[63:0] == '0)
    else $error("nonzero value with error status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[66:64] <= ST_NOT_DIGIT)
    else $error("status code out of range");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE || phase == PH_ZERO || phase == PH_DIGITS)
    else $error("illegal scanner phase");

  a_emit_idles: assert property (@(posedge clk) disable iff (rst)
    advance && step.emit |=> phase == PH_IDLE && accum == '0 && m_tvalid)
    else $error("scanner not idle after a result");

endmodule
